// File: sv/lppd_pkg.sv
`default_nettype none

package lppd_pkg;

    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 16;
    localparam int CFG_IDX_W  = 4;

    localparam int RESULT_DEPTH = 4;

    localparam logic [LEN_W-1:0] MIN_PACKET_SIZE_RST = 16'd4;
    localparam logic [LEN_W-1:0] MAX_PACKET_SIZE_RST = 16'd4096;
    localparam logic [LEN_W-1:0] HEADER_LEN          = 16'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_PACKET_SIZE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PACKET_SIZE = 4'd1;

    typedef enum logic [1:0] {
        PH_LOW,
        PH_HIGH,
        PH_BODY,
        PH_DEAD
    } t_phase;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_BELOW_MIN,
        ERR_ABOVE_MAX
    } t_err;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              first_of_packet;
        logic              last_of_packet;
        t_err              length_error;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_push;

endpackage

`default_nettype wire

// File: sv/lppd_rfifo.sv
`default_nettype none

module lppd_rfifo #(
    parameter int Depth = lppd_pkg::RESULT_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire lppd_pkg::t_push i_push,
    output logic                 o_room2,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output lppd_pkg::t_result    o_result
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    lppd_pkg::t_result r_mem [Depth];
    logic [PtrW-1:0]   r_wr;
    logic [PtrW-1:0]   r_rd;
    logic [CntW-1:0]   r_count;
    logic [PtrW-1:0]   n_wr;
    logic [PtrW-1:0]   n_rd;
    logic [CntW-1:0]   n_count;
    logic [PtrW-1:0]   wr1;
    logic [PtrW-1:0]   wr2;
    logic              pop;

    assign o_valid  = (r_count != '0);
    assign o_room2  = (r_count <= CntW'(Depth - 2));
    assign o_result = r_mem[r_rd];
    assign pop      = o_valid && i_ready;

    always_comb begin
        wr1 = (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
        wr2 = (wr1 == PtrW'(Depth - 1)) ? '0 : wr1 + 1'b1;
        unique case (i_push.count)
            2'd1:    n_wr = wr1;
            2'd2:    n_wr = wr2;
            default: n_wr = r_wr;
        endcase
        if (pop) begin
            n_rd = (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
        end else begin
            n_rd = r_rd;
        end
        n_count = r_count + CntW'(i_push.count) - CntW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr1] <= i_push.r1;
        end
    end

endmodule

`default_nettype wire

// File: sv/length_prefix_packet_deframer.sv
`default_nettype none

// Channel   Direction  Handshake                  Payload
// rx        in         i_rx_valid / o_rx_ready    i_rx_byte
// out       out        o_out_valid / i_out_ready  o_out_byte, o_first_of_packet,
//                                                 o_last_of_packet, o_length_error
// cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One rx byte per cycle; results leave through a small result queue, one per cycle.
// A good length pushes two results in one cycle; rx is ready while the queue has
// room for two, so a byte per cycle is sustained while out is not stalled.
// Synchronous active-low reset clears phase, counters and queue pointers and
// restores the default limits.
// A bad length reports once and then drops every byte until reset.

module length_prefix_packet_deframer #(
    parameter int ResultDepth = lppd_pkg::RESULT_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_rx_valid,
    output logic                                o_rx_ready,
    input  wire logic [lppd_pkg::BYTE_W-1:0]    i_rx_byte,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [lppd_pkg::BYTE_W-1:0]         o_out_byte,
    output logic                                o_first_of_packet,
    output logic                                o_last_of_packet,
    output logic [1:0]                          o_length_error,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [lppd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [lppd_pkg::LEN_W-1:0]     i_cfg_data
);

    lppd_pkg::t_phase                r_phase;
    lppd_pkg::t_phase                n_phase;
    logic [lppd_pkg::BYTE_W-1:0]     r_held_low_byte;
    logic [lppd_pkg::LEN_W-1:0]      r_frame_length;
    logic [lppd_pkg::LEN_W-1:0]      r_bytes_taken;
    logic [lppd_pkg::LEN_W-1:0]      n_bytes_taken;
    logic [lppd_pkg::LEN_W-1:0]      r_min_packet_size;
    logic [lppd_pkg::LEN_W-1:0]      r_max_packet_size;
    logic [lppd_pkg::LEN_W-1:0]      len;
    logic                            err_below;
    logic                            err_above;
    logic                            len_is_header;
    logic                            body_last;
    logic                            rx_xfer;
    logic                            room2;
    lppd_pkg::t_push                 push;
    lppd_pkg::t_result               result;

    assign o_cfg_ready = 1'b1;
    assign o_rx_ready  = room2;
    assign rx_xfer     = i_rx_valid && room2;

    assign len           = {i_rx_byte, r_held_low_byte};
    assign err_below     = (len < lppd_pkg::HEADER_LEN) || (len < r_min_packet_size);
    assign err_above     = (len > r_max_packet_size);
    assign len_is_header = (len == lppd_pkg::HEADER_LEN);
    assign n_bytes_taken = r_bytes_taken + 1'b1;
    assign body_last     = (n_bytes_taken >= r_frame_length);

    always_comb begin
        n_phase = r_phase;
        if (rx_xfer) begin
            unique case (r_phase)
                lppd_pkg::PH_LOW: n_phase = lppd_pkg::PH_HIGH;
                lppd_pkg::PH_HIGH: begin
                    if (err_below || err_above) begin
                        n_phase = lppd_pkg::PH_DEAD;
                    end else if (len_is_header) begin
                        n_phase = lppd_pkg::PH_LOW;
                    end else begin
                        n_phase = lppd_pkg::PH_BODY;
                    end
                end
                lppd_pkg::PH_BODY: n_phase = body_last ? lppd_pkg::PH_LOW : lppd_pkg::PH_BODY;
                default:           n_phase = lppd_pkg::PH_DEAD;
            endcase
        end
    end

    always_comb begin
        push       = '0;
        push.r0.length_error = lppd_pkg::ERR_NONE;
        push.r1.length_error = lppd_pkg::ERR_NONE;
        if (rx_xfer) begin
            unique case (r_phase)
                lppd_pkg::PH_HIGH: begin
                    priority if (err_below) begin
                        push.count           = 2'd1;
                        push.r0.length_error = lppd_pkg::ERR_BELOW_MIN;
                    end else if (err_above) begin
                        push.count           = 2'd1;
                        push.r0.length_error = lppd_pkg::ERR_ABOVE_MAX;
                    end else begin
                        push.count              = 2'd2;
                        push.r0.out_byte        = r_held_low_byte;
                        push.r0.first_of_packet = 1'b1;
                        push.r1.out_byte        = i_rx_byte;
                        push.r1.last_of_packet  = len_is_header;
                    end
                end
                lppd_pkg::PH_BODY: begin
                    push.count             = 2'd1;
                    push.r0.out_byte       = i_rx_byte;
                    push.r0.last_of_packet = body_last;
                end
                default: push.count = 2'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= lppd_pkg::PH_LOW;
            r_held_low_byte   <= '0;
            r_frame_length    <= '0;
            r_bytes_taken     <= '0;
            r_min_packet_size <= lppd_pkg::MIN_PACKET_SIZE_RST;
            r_max_packet_size <= lppd_pkg::MAX_PACKET_SIZE_RST;
        end else begin
            r_phase <= n_phase;
            if (rx_xfer && r_phase == lppd_pkg::PH_LOW) begin
                r_held_low_byte <= i_rx_byte;
            end
            if (rx_xfer && r_phase == lppd_pkg::PH_HIGH && !err_below && !err_above) begin
                r_frame_length <= len;
                r_bytes_taken  <= lppd_pkg::HEADER_LEN;
            end
            if (rx_xfer && r_phase == lppd_pkg::PH_BODY) begin
                r_bytes_taken <= n_bytes_taken;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    lppd_pkg::CFG_MIN_PACKET_SIZE: r_min_packet_size <= i_cfg_data;
                    lppd_pkg::CFG_MAX_PACKET_SIZE: r_max_packet_size <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    lppd_rfifo #(
        .Depth (ResultDepth)
    ) u_rfifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_room2  (room2),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (result)
    );

    assign o_out_byte        = result.out_byte;
    assign o_first_of_packet = result.first_of_packet;
    assign o_last_of_packet  = result.last_of_packet;
    assign o_length_error    = result.length_error;

endmodule

`default_nettype wire
